[hw/rtl/cplm_pkg.sv]
// Shared definitions for the colour palette learn/match block.
// Request and register codes, reset values, command/status structs and helpers.
// No dependencies.
`default_nettype none

package cplm_pkg;

    localparam int unsigned PALETTE_DEPTH_DEF = 64;

    localparam logic [7:0] TOL_RESET   = 8'd32;
    localparam logic [7:0] WHITE_RESET = 8'd250;

    // request codes
    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_LEARN = 2'd1;
    localparam logic [1:0] REQ_MATCH = 2'd2;

    // configuration register indexes
    localparam logic CFG_TOLERANCE   = 1'b0;
    localparam logic CFG_WHITE_LIMIT = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic load;         // latch the incoming item, rewind the scan index
        logic rd_en;        // read the palette entry at the scan index
        logic inc_idx;      // advance the scan index
        logic res_load;     // capture the result item
        logic res_matched;
        logic res_stored;
        logic res_dropped;
        logic wr_en;        // append the colour to the palette
        logic clr_count;    // empty the palette
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] req;
        logic       white;
        logic       count_zero;
        logic       full;
        logic       idx_last;
        logic       hit;
        logic       out_free;
    } status_t;

    function automatic logic [9:0] chan_sum(input logic [23:0] c);
        chan_sum = 10'(c[23:16]) + 10'(c[15:8]) + 10'(c[7:0]);
    endfunction

    function automatic logic [9:0] abs_diff10(input logic [9:0] a, input logic [9:0] b);
        abs_diff10 = (a >= b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [7:0] abs_diff8(input logic [7:0] a, input logic [7:0] b);
        abs_diff8 = (a >= b) ? (a - b) : (b - a);
    endfunction

endpackage

`default_nettype wire

[hw/rtl/cplm_dp.sv]
// Datapath: palette memory, entry count, scan index, comparators,
// configuration registers and the output register. Uses cplm_pkg.
`default_nettype none

module cplm_dp #(
    parameter int unsigned PALETTE_DEPTH = cplm_pkg::PALETTE_DEPTH_DEF,
    parameter int unsigned CNT_W         = $clog2(PALETTE_DEPTH + 1),
    parameter int unsigned IDX_W         = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  cplm_pkg::cmd_t        cmd,
    output cplm_pkg::status_t     status,
    input  wire  [1:0]            req_type,
    input  wire  [23:0]           color,
    input  wire                   out_ready,
    input  wire                   cfg_we,
    input  wire                   cfg_index,
    input  wire  [7:0]            cfg_data,
    output logic                  out_valid,
    output logic                  matched,
    output logic                  stored,
    output logic                  dropped_full,
    output logic [6:0]            entry_count
);

    logic [23:0]      palette_mem [PALETTE_DEPTH];

    logic [1:0]       req_reg;
    logic [23:0]      color_reg;
    logic [9:0]       sum_reg;
    logic [23:0]      rd_data_reg;
    logic [IDX_W-1:0] idx_reg,   idx_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       tol_reg,   tol_next;
    logic [7:0]       white_reg, white_next;
    logic             out_valid_reg, out_valid_next;
    logic             matched_reg, stored_reg, dropped_reg;
    logic [6:0]       entry_count_reg;

    logic [CNT_W-1:0] idx_ext;
    logic [CNT_W+6:0] count_wide;
    logic             learn_hit;
    logic             match_hit;

    // scan index
    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.load)
        begin
            idx_next = '0;
        end
        else if (cmd.inc_idx)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    // entry count
    always_comb
    begin
        count_next = count_reg;
        if (cmd.clr_count)
        begin
            count_next = '0;
        end
        else if (cmd.wr_en)
        begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    // configuration registers
    always_comb
    begin
        tol_next   = tol_reg;
        white_next = white_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                cplm_pkg::CFG_TOLERANCE:   tol_next   = cfg_data;
                cplm_pkg::CFG_WHITE_LIMIT: white_next = cfg_data;
                default:                   tol_next   = tol_reg;
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            count_reg     <= '0;
            tol_reg       <= cplm_pkg::TOL_RESET;
            white_reg     <= cplm_pkg::WHITE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            count_reg     <= count_next;
            tol_reg       <= tol_next;
            white_reg     <= white_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // item payload and result fields
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg   <= req_type;
            color_reg <= color;
            sum_reg   <= cplm_pkg::chan_sum(color);
        end
        if (cmd.res_load)
        begin
            matched_reg     <= cmd.res_matched;
            stored_reg      <= cmd.res_stored;
            dropped_reg     <= cmd.res_dropped;
            entry_count_reg <= count_wide[6:0];
        end
    end

    // palette memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            palette_mem[count_reg[IDX_W-1:0]] <= color_reg;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= palette_mem[idx_reg];
        end
    end

    assign count_wide = {7'd0, count_next};
    assign idx_ext    = CNT_W'(idx_reg);

    assign learn_hit = cplm_pkg::abs_diff10(cplm_pkg::chan_sum(rd_data_reg), sum_reg)
                       < 10'(tol_reg[7:2]);

    assign match_hit = (cplm_pkg::abs_diff8(color_reg[23:16], rd_data_reg[23:16]) <= tol_reg)
                    && (cplm_pkg::abs_diff8(color_reg[15:8],  rd_data_reg[15:8])  <= tol_reg)
                    && (cplm_pkg::abs_diff8(color_reg[7:0],   rd_data_reg[7:0])   <= tol_reg);

    assign status.req        = req_reg;
    assign status.white      = (color_reg[23:16] > white_reg) && (color_reg[15:8] > white_reg)
                            && (color_reg[7:0] > white_reg);
    assign status.count_zero = (count_reg == '0);
    assign status.full       = (count_reg == CNT_W'(PALETTE_DEPTH));
    assign status.idx_last   = (CNT_W'(idx_ext + CNT_W'(1)) == count_reg);
    assign status.hit        = (req_reg == cplm_pkg::REQ_LEARN) ? learn_hit : match_hit;
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign matched      = matched_reg;
    assign stored       = stored_reg;
    assign dropped_full = dropped_reg;
    assign entry_count  = entry_count_reg;

endmodule

`default_nettype wire

[hw/rtl/cplm_ctrl.sv]
// Controller: sequences one item at a time through the palette scan.
// Drives cmd_t to the datapath, reads status_t back. Uses cplm_pkg.
`default_nettype none

module cplm_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_ready,
    input  cplm_pkg::status_t    status,
    output cplm_pkg::cmd_t       cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_CMP   = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       found_reg, found_next;
    logic       is_learn;
    logic       is_match;

    assign is_learn = (status.req == cplm_pkg::REQ_LEARN);
    assign is_match = (status.req == cplm_pkg::REQ_MATCH);
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        found_next = found_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    found_next = 1'b0;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                // skip the scan for an empty palette, a white pixel in a match, or no search
                if ((is_learn || (is_match && !status.white)) && !status.count_zero)
                begin
                    state_next = S_READ;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (status.hit)
                begin
                    found_next = 1'b1;
                    state_next = S_FIN;
                end
                else if (status.idx_last)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.inc_idx = 1'b1;
                    state_next  = S_READ;
                end
            end
            S_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.res_load    = 1'b1;
                    cmd.clr_count   = (status.req == cplm_pkg::REQ_CLEAR);
                    cmd.res_matched = is_match && found_reg;
                    cmd.res_stored  = is_learn && !found_reg && !status.full;
                    cmd.res_dropped = is_learn && !found_reg && status.full;
                    cmd.wr_en       = is_learn && !found_reg && !status.full;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            found_reg <= found_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/color_palette_learn_match.sv]
// Colour palette learn/match: no palette scan runs when there is nothing to search
// (clear, unused code, white pixel in a match, empty palette); otherwise each entry
// examined costs one palette memory read plus compare.
// One item at a time: the next item is taken the cycle after the result is registered.
// Reset clears the entry count and output valid and loads tolerance 32, white limit 250;
// the palette memory is not cleared, entries at or above the count are never read.
`default_nettype none

module color_palette_learn_match #(
    parameter int unsigned PALETTE_DEPTH = cplm_pkg::PALETTE_DEPTH_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    // item input
    input  wire         in_valid,
    output logic        in_ready,
    input  wire  [1:0]  req_type,
    input  wire  [23:0] color,
    // result output
    output logic        out_valid,
    input  wire         out_ready,
    output logic        matched,
    output logic        stored,
    output logic        dropped_full,
    output logic [6:0]  entry_count,
    // configuration writes
    input  wire         cfg_we,
    input  wire         cfg_index,
    input  wire  [7:0]  cfg_data
);

    // count holds 0..PALETTE_DEPTH, the index addresses entries 0..PALETTE_DEPTH-1
    localparam int unsigned CNT_W = $clog2(PALETTE_DEPTH + 1);
    localparam int unsigned IDX_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

    cplm_pkg::cmd_t    cmd;
    cplm_pkg::status_t status;

    // sequencer: accept, decide whether to scan, walk entries, emit the result
    cplm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // storage and arithmetic: palette memory, comparators, output register
    cplm_dp #(
        .PALETTE_DEPTH (PALETTE_DEPTH),
        .CNT_W         (CNT_W),
        .IDX_W         (IDX_W)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .req_type     (req_type),
        .color        (color),
        .out_ready    (out_ready),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .matched      (matched),
        .stored       (stored),
        .dropped_full (dropped_full),
        .entry_count  (entry_count)
    );

endmodule

`default_nettype wire

[test/tb_top.sv]
// Self-checking testbench for color_palette_learn_match: random and directed clear,
// learn and match items against a behavioural palette predictor, with random stalls.
// Depends on hw/rtl/cplm_pkg.sv and hw/rtl/color_palette_learn_match.sv with its cplm_dp and cplm_ctrl.
`default_nettype none

module tb_top;

    localparam int DEPTH       = cplm_pkg::PALETTE_DEPTH_DEF;
    // Limit for the whole run, well above what an honest run needs.
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int HOLD_CYCLES = 300;

    // request code with no meaning: the block must leave the palette alone
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  req;
        logic [23:0] color;
    } request_t;

    typedef struct packed {
        logic       matched;
        logic       stored;
        logic       dropped_full;
        logic [6:0] entry_count;
    } outcome_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  req_type = cplm_pkg::REQ_CLEAR;
    logic [23:0] color = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        matched;
    logic        stored;
    logic        dropped_full;
    logic [6:0]  entry_count;
    logic        cfg_we = 1'b0;
    logic        cfg_index = cplm_pkg::CFG_TOLERANCE;
    logic [7:0]  cfg_data = '0;

    // Items waiting to be offered, and outcomes waiting for the block to produce them.
    request_t queued_requests[$];
    outcome_t pending_outcomes[$];

    // Predictor copy of the palette and of the two registers.
    logic [23:0] pal_mem [DEPTH];
    int          pal_cnt = 0;
    logic [7:0]  tol_q   = cplm_pkg::TOL_RESET;
    logic [7:0]  white_q = cplm_pkg::WHITE_RESET;

    // Colours already offered for learning since the last clear; used to aim matches.
    logic [23:0] offered_colors[$];

    int  fails = 0;
    int  cycles = 0;
    bit  no_idle = 1'b0;
    int  hold_asked = 0;
    int  hold_given = 0;
    // items taken off the queue whose result has not been taken yet
    int  in_flight = 0;

    color_palette_learn_match dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .color        (color),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .matched      (matched),
        .stored       (stored),
        .dropped_full (dropped_full),
        .entry_count  (entry_count),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int gap_span(input int a, input int b);
        return (a >= b) ? a - b : b - a;
    endfunction

    function automatic int rgb_total(input logic [23:0] c);
        return int'(c[23:16]) + int'(c[15:8]) + int'(c[7:0]);
    endfunction

    // Work out what one item does to the palette and what the block must report.
    function automatic outcome_t palette_outcome(input logic [1:0] req, input logic [23:0] c);
        outcome_t o;
        int       s;
        bit       dup;
        bit       white;
        o = '0;
        case (req)
            cplm_pkg::REQ_CLEAR:
                pal_cnt = 0;
            cplm_pkg::REQ_LEARN:
            begin
                s   = rgb_total(c);
                dup = 1'b0;
                // a sum closer than a quarter of the tolerance counts as already known
                for (int i = 0; i < pal_cnt; i++)
                    if (gap_span(rgb_total(pal_mem[i]), s) < int'(tol_q >> 2))
                        dup = 1'b1;
                if (!dup)
                begin
                    if (pal_cnt < DEPTH)
                    begin
                        pal_mem[pal_cnt] = c;
                        pal_cnt++;
                        o.stored = 1'b1;
                    end
                    else
                        o.dropped_full = 1'b1;
                end
            end
            cplm_pkg::REQ_MATCH:
            begin
                // white pixels never match, whatever the palette holds
                white = (c[23:16] > white_q) && (c[15:8] > white_q) && (c[7:0] > white_q);
                if (!white)
                    for (int i = 0; i < pal_cnt; i++)
                        if (gap_span(c[23:16], pal_mem[i][23:16]) <= int'(tol_q) &&
                            gap_span(c[15:8],  pal_mem[i][15:8])  <= int'(tol_q) &&
                            gap_span(c[7:0],   pal_mem[i][7:0])   <= int'(tol_q))
                            o.matched = 1'b1;
            end
            default: ;  // unused code: no change, zeros and the current count
        endcase
        o.entry_count = 7'(pal_cnt);
        return o;
    endfunction

    // Sender gaps: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Move one channel by a random amount within +/- span, clamped to 0..255.
    function automatic logic [7:0] nudge(input logic [7:0] ch, input int span);
        int v;
        v = int'(ch) + int'($urandom_range(0, 2 * span)) - span;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return 8'(v);
    endfunction

    function automatic logic [23:0] nudge_rgb(input logic [23:0] c, input int span);
        return {nudge(c[23:16], span), nudge(c[15:8], span), nudge(c[7:0], span)};
    endfunction

    task automatic push_item(input logic [1:0] req, input logic [23:0] c);
        request_t it;
        it.req   = req;
        it.color = c;
        queued_requests = {queued_requests, it};
        if (req == cplm_pkg::REQ_CLEAR)
            offered_colors.delete();
        else if (req == cplm_pkg::REQ_LEARN)
            offered_colors = {offered_colors, c};
    endtask

    // Write one register while the block is idle; the predictor updates when the write is driven.
    task automatic write_reg(input logic idx, input logic [7:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == cplm_pkg::CFG_TOLERANCE)
            tol_q = val;
        else
            white_q = val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (queued_requests.size() != 0 || in_flight != 0)
            @(posedge clk);
    endtask

    // Random phase: learn_pct is the share of learn items, clear_pm the clear rate per mille.
    task automatic random_phase(input int n, input int learn_pct, input int clear_pm);
        int          r;
        int          rr;
        logic [23:0] c;
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(0, 999);
            c = 24'($urandom);
            if (r < clear_pm)
                push_item(cplm_pkg::REQ_CLEAR, c);
            else if (r < clear_pm + 15)
                push_item(REQ_UNUSED, c);
            else if (r < clear_pm + 15 + learn_pct * 10)
            begin
                // aim some learns at the duplicate threshold of an earlier colour
                if (offered_colors.size() != 0 && $urandom_range(0, 2) == 0)
                    c = nudge_rgb(offered_colors[$urandom_range(0, offered_colors.size() - 1)],
                                  int'(tol_q >> 2) + 1);
                push_item(cplm_pkg::REQ_LEARN, c);
            end
            else
            begin
                rr = $urandom_range(0, 9);
                if (rr < 6 && offered_colors.size() != 0)
                    c = nudge_rgb(offered_colors[$urandom_range(0, offered_colors.size() - 1)],
                                  int'(tol_q) + 1);
                else if (rr == 6)
                    c = {8'($urandom_range(white_q, 255)), 8'($urandom_range(white_q, 255)),
                         8'($urandom_range(white_q, 255))};
                push_item(cplm_pkg::REQ_MATCH, c);
            end
        end
    endtask

    // Driver: offer queued items, hold each until taken, predict at acceptance.
    int gap_left = 0;
    always @(posedge clk)
    begin
        bit       take;
        bit       next_valid;
        request_t it;
        take       = in_valid && in_ready;
        next_valid = in_valid;
        if (rst_n)
        begin
            if (take)
            begin
                pending_outcomes = {pending_outcomes, palette_outcome(req_type, color)};
                gap_left = pick_gap();
            end
            if (!in_valid || take)
            begin
                next_valid = 1'b0;
                if (gap_left > 0)
                    gap_left--;
                else if (queued_requests.size() != 0)
                begin
                    it = queued_requests[0];
                    queued_requests.delete(0);
                    in_flight++;
                    req_type   <= it.req;
                    color      <= it.color;
                    next_valid = 1'b1;
                end
            end
        end
        in_valid <= next_valid;
    end

    // Monitor: check each taken result against the oldest outcome, then pick next ready.
    int stall_left = 0;
    int hold_left  = 0;
    always @(posedge clk)
    begin
        outcome_t want;
        bit       rdy;
        if (out_valid && out_ready)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $error("result with no outstanding item: matched=%0d stored=%0d", matched,
                       stored);
                fails++;
            end
            else
            begin
                want = pending_outcomes[0];
                pending_outcomes.delete(0);
                in_flight--;
                if (matched !== want.matched)
                begin
                    $error("matched: expected %0d, got %0d", want.matched, matched);
                    fails++;
                end
                if (stored !== want.stored)
                begin
                    $error("stored: expected %0d, got %0d", want.stored, stored);
                    fails++;
                end
                if (dropped_full !== want.dropped_full)
                begin
                    $error("dropped_full: expected %0d, got %0d", want.dropped_full,
                           dropped_full);
                    fails++;
                end
                if (entry_count !== want.entry_count)
                begin
                    $error("entry_count: expected %0d, got %0d", want.entry_count,
                           entry_count);
                    fails++;
                end
            end
        end
        // a long hold-off on request, so the block backs up and stalls its input
        if (hold_asked != hold_given)
        begin
            hold_given = hold_asked;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rdy = 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            rdy = 1'b0;
        end
        else
        begin
            rdy = 1'b1;
            if (!no_idle && $urandom_range(0, 99) < 30)
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                          : $urandom_range(1, 3);
        end
        out_ready <= rdy;
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed items at the reset settings (tolerance 32, so the sum threshold is 8).
        push_item(cplm_pkg::REQ_MATCH, 24'h000000);   // empty palette never matches
        push_item(REQ_UNUSED,          24'h000000);   // unused code
        push_item(cplm_pkg::REQ_LEARN, 24'h000000);
        push_item(cplm_pkg::REQ_LEARN, 24'h010101);   // sum 3 away: duplicate
        push_item(cplm_pkg::REQ_LEARN, 24'hFFFFFF);
        push_item(cplm_pkg::REQ_LEARN, 24'h080000);   // sum exactly at the threshold: new
        push_item(cplm_pkg::REQ_MATCH, 24'h202020);   // every channel exactly at the tolerance
        push_item(cplm_pkg::REQ_MATCH, 24'h212121);   // one past it
        push_item(cplm_pkg::REQ_MATCH, 24'hFBFBFB);   // white, though near a stored entry
        push_item(cplm_pkg::REQ_MATCH, 24'hFAFBFB);   // one channel at the limit: not white
        push_item(cplm_pkg::REQ_MATCH, 24'hFF00FF);
        push_item(REQ_UNUSED,          24'hFFFFFF);
        push_item(cplm_pkg::REQ_CLEAR, 24'hFFFFFF);
        push_item(cplm_pkg::REQ_MATCH, 24'h000000);   // palette empty again
        push_item(cplm_pkg::REQ_LEARN, 24'hFF0000);
        push_item(cplm_pkg::REQ_LEARN, 24'h00FF00);   // same sum, other colour: duplicate
        push_item(cplm_pkg::REQ_LEARN, 24'h0000FF);
        push_item(cplm_pkg::REQ_MATCH, 24'hDF2020);
        push_item(cplm_pkg::REQ_MATCH, 24'hFFFFFF);
        push_item(cplm_pkg::REQ_CLEAR, 24'h000000);
        wait_drained();

        // Zero threshold: nothing is a duplicate, so the palette fills and overflows.
        write_reg(cplm_pkg::CFG_TOLERANCE, 8'd0);
        write_reg(cplm_pkg::CFG_WHITE_LIMIT, 8'd255);
        random_phase(350, 55, 2);
        wait_drained();

        // Widest tolerance, every pixel with no zero channel white; receiver holds off for a while.
        write_reg(cplm_pkg::CFG_TOLERANCE, 8'd255);
        write_reg(cplm_pkg::CFG_WHITE_LIMIT, 8'd0);
        hold_asked++;
        random_phase(300, 40, 20);
        wait_drained();

        // Smallest non-zero threshold, no idling on either side.
        no_idle = 1'b1;
        write_reg(cplm_pkg::CFG_TOLERANCE, 8'd4);
        write_reg(cplm_pkg::CFG_WHITE_LIMIT, 8'd128);
        random_phase(300, 50, 10);
        wait_drained();
        no_idle = 1'b0;

        // Tolerance 3 still gives a zero threshold; back to the usual white limit.
        write_reg(cplm_pkg::CFG_TOLERANCE, 8'd3);
        write_reg(cplm_pkg::CFG_WHITE_LIMIT, 8'd250);
        random_phase(300, 50, 5);
        wait_drained();

        // Random settings for the rest.
        for (int p = 0; p < 3; p++)
        begin
            write_reg(cplm_pkg::CFG_TOLERANCE, 8'($urandom_range(0, 255)));
            write_reg(cplm_pkg::CFG_WHITE_LIMIT, 8'($urandom_range(0, 255)));
            if (p == 1)
                hold_asked++;
            random_phase(260, 45, 8);
            wait_drained();
        end

        // Drain and let the block settle before the verdict.
        repeat (10) @(posedge clk);
        if (fails == 0 && pending_outcomes.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
hw/rtl/cplm_pkg.sv
hw/rtl/cplm_dp.sv
hw/rtl/cplm_ctrl.sv
hw/rtl/color_palette_learn_match.sv
test/tb_top.sv
